// ===== rtl/lpwb_pkg.sv =====
// shared types, codes and reset values of the page write buffer
package lpwb_pkg;

	localparam int ENTRIES_DEFAULT = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_INIT_CODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES = 1'd1;

	localparam logic [1:0]            INIT_CODE_RESET  = 2'd1;
	localparam logic [CFG_DATA_W-1:0] PAGE_BYTES_RESET = 17'd4096;

	typedef enum logic [2:0] {
		OP_BUF_WRITE     = 3'd0,
		OP_WRITE_THROUGH = 3'd1,
		OP_READ          = 3'd2,
		OP_UNBUFFER      = 3'd3,
		OP_FLUSH_OBJECT  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ACT_DONE          = 3'd0,
		ACT_FWD_WRITE     = 3'd1,
		ACT_FWD_READ      = 3'd2,
		ACT_SUPPLY        = 3'd3,
		ACT_DISCARD       = 3'd4,
		ACT_FWD_TERMINATE = 3'd5
	} act_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] object_id;
		logic [31:0] page_offset;
		logic [31:0] data_handle;
		logic        dirty_in;
		logic        kernel_copy_in;
		logic [1:0]  use_mode_in;
		logic        clean;
		logic [31:0] length_in;
		logic [2:0]  access_in;
		logic        release_in;
	} req_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] out_object;
		logic [31:0] out_offset;
		logic [31:0] out_handle;
		logic        out_dirty;
		logic        out_kernel_copy;
		logic [1:0]  out_use_mode;
		logic [31:0] out_length;
		logic [2:0]  out_access;
		logic        out_release;
		logic        last;
	} rsp_t;

	// one table entry: attrs bit 0 dirty, bit 1 kernel copy, bits 3:2 use mode
	typedef struct packed {
		logic [15:0] object_id;
		logic [31:0] page_offset;
		logic [31:0] handle;
		logic [3:0]  attrs;
	} entry_t;

	// table change requested by the sequencer once the sweep results are known
	typedef enum logic [2:0] {
		UPD_NONE         = 3'd0,
		UPD_TOUCH_HIT    = 3'd1,
		UPD_DROP_HIT     = 3'd2,
		UPD_DROP_CAND    = 3'd3,
		UPD_INSERT_FREE  = 3'd4,
		UPD_REPLACE_CAND = 3'd5
	} upd_t;

	typedef enum logic [2:0] {
		RK_NONE    = 3'd0,
		RK_TOUCH   = 3'd1,
		RK_DROP    = 3'd2,
		RK_INSERT  = 3'd3,
		RK_REPLACE = 3'd4
	} rank_t;

	typedef struct packed {
		logic        start;
		logic        flush_search;
		logic [15:0] key_object;
		logic [31:0] key_offset;
		upd_t        upd;
		logic        wr_en;
		entry_t      wr_ent;
	} tbl_cmd_t;

	typedef struct packed {
		logic   done;
		logic   hit;
		logic   free_found;
		logic   cand_found;
		entry_t hit_ent;
		entry_t cand_ent;
	} tbl_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_DECIDE = 2'd2,
		ST_SECOND = 2'd3
	} state_t;

endpackage

// ===== rtl/lpwb_table.sv =====
// entry table with its sweep engine: tag match, free slot, lru or flush pick, rank upkeep
module lpwb_table #(
	parameter int ENTRIES = lpwb_pkg::ENTRIES_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpwb_pkg::tbl_cmd_t  cmd,
	output lpwb_pkg::tbl_stat_t stat
);
	import lpwb_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int AW = IW;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	logic [ENTRIES-1:0] valid_q;
	entry_t             ent_mem   [ENTRIES];
	logic [AW-1:0]      age_mem   [ENTRIES];
	logic [AW-1:0]      birth_mem [ENTRIES];

	logic          sweep_q;
	logic [IW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	entry_t        ent_s1;
	logic [AW-1:0] age_s1;
	logic [AW-1:0] birth_s1;

	rank_t         pend_q;
	logic [IW-1:0] pend_idx_q;
	logic [AW-1:0] pend_age_q;
	logic [AW-1:0] pend_birth_q;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	entry_t        hit_ent_q;
	logic [AW-1:0] hit_age_q;
	logic [AW-1:0] hit_birth_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic          cand_q;
	logic [IW-1:0] cand_idx_q;
	entry_t        cand_ent_q;
	logic [AW-1:0] cand_age_q;
	logic [AW-1:0] cand_birth_q;
	logic          done_q;

	logic          cur_v;
	logic          is_t;
	logic [AW-1:0] age_n;
	logic [AW-1:0] birth_n;
	logic          obj_eq;
	logic          key_eq;
	logic          hit_take;
	logic          free_take;
	logic          cand_take;
	logic          rank_we;

	rank_t         c_kind;
	logic [IW-1:0] c_idx;
	logic [AW-1:0] c_age;
	logic [AW-1:0] c_birth;
	logic          c_set;
	logic          c_clr;

	// sweep: one entry read per cycle, processed in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= 1'b0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cmd.start) begin
				sweep_q <= 1'b1;
				cnt_q   <= '0;
			end else if (sweep_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_IDX) begin
					sweep_q <= 1'b0;
				end
			end
			rd_vld_s1 <= sweep_q;
			rd_idx_s1 <= cnt_q;
			done_q    <= rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			ent_s1 <= ent_mem[cnt_q];
		end
		if (cmd.wr_en) begin
			ent_mem[c_idx] <= cmd.wr_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			age_s1   <= age_mem[cnt_q];
			birth_s1 <= birth_mem[cnt_q];
		end
		if (rank_we) begin
			age_mem[rd_idx_s1]   <= age_n;
			birth_mem[rd_idx_s1] <= birth_n;
		end
	end

	// the rank change left by the previous commit is applied as the sweep passes
	always_comb begin
		cur_v   = rd_vld_s1 && valid_q[rd_idx_s1];
		is_t    = (rd_idx_s1 == pend_idx_q);
		age_n   = age_s1;
		birth_n = birth_s1;
		case (pend_q)
			RK_TOUCH: begin
				if (is_t) begin
					age_n = '0;
				end else begin
					age_n = age_s1 + AW'(age_s1 < pend_age_q);
				end
			end
			RK_DROP: begin
				age_n   = age_s1 - AW'(age_s1 > pend_age_q);
				birth_n = birth_s1 - AW'(birth_s1 > pend_birth_q);
			end
			RK_INSERT: begin
				if (is_t) begin
					age_n   = '0;
					birth_n = '0;
				end else begin
					age_n   = age_s1 + AW'(1'b1);
					birth_n = birth_s1 + AW'(1'b1);
				end
			end
			RK_REPLACE: begin
				if (is_t) begin
					age_n   = '0;
					birth_n = '0;
				end else begin
					age_n   = age_s1 - AW'(age_s1 > pend_age_q) + AW'(1'b1);
					birth_n = birth_s1 - AW'(birth_s1 > pend_birth_q) + AW'(1'b1);
				end
			end
			default: begin
				age_n   = age_s1;
				birth_n = birth_s1;
			end
		endcase
		rank_we = cur_v && (pend_q != RK_NONE);
	end

	always_comb begin
		obj_eq    = (ent_s1.object_id == cmd.key_object);
		key_eq    = obj_eq && (ent_s1.page_offset == cmd.key_offset);
		hit_take  = cur_v && key_eq && !hit_q;
		free_take = rd_vld_s1 && !valid_q[rd_idx_s1] && !free_q;
		if (cmd.flush_search) begin
			// oldest insertion of the object
			cand_take = cur_v && obj_eq && (!cand_q || (birth_n > cand_birth_q));
		end else begin
			// least recently used
			cand_take = cur_v && (!cand_q || (age_n > cand_age_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			cand_q <= 1'b0;
		end else if (cmd.start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			cand_q <= 1'b0;
		end else begin
			if (hit_take) begin
				hit_q <= 1'b1;
			end
			if (free_take) begin
				free_q <= 1'b1;
			end
			if (cand_take) begin
				cand_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_take) begin
			hit_idx_q   <= rd_idx_s1;
			hit_ent_q   <= ent_s1;
			hit_age_q   <= age_n;
			hit_birth_q <= birth_n;
		end
		if (free_take) begin
			free_idx_q <= rd_idx_s1;
		end
		if (cand_take) begin
			cand_idx_q   <= rd_idx_s1;
			cand_ent_q   <= ent_s1;
			cand_age_q   <= age_n;
			cand_birth_q <= birth_n;
		end
	end

	// commit: pick the entry and rank change named by the sequencer
	always_comb begin
		c_kind  = RK_NONE;
		c_idx   = hit_idx_q;
		c_age   = hit_age_q;
		c_birth = hit_birth_q;
		c_set   = 1'b0;
		c_clr   = 1'b0;
		case (cmd.upd)
			UPD_TOUCH_HIT: begin
				c_kind = RK_TOUCH;
			end
			UPD_DROP_HIT: begin
				c_kind = RK_DROP;
				c_clr  = 1'b1;
			end
			UPD_DROP_CAND: begin
				c_kind  = RK_DROP;
				c_idx   = cand_idx_q;
				c_age   = cand_age_q;
				c_birth = cand_birth_q;
				c_clr   = 1'b1;
			end
			UPD_INSERT_FREE: begin
				c_kind = RK_INSERT;
				c_idx  = free_idx_q;
				c_set  = 1'b1;
			end
			UPD_REPLACE_CAND: begin
				c_kind  = RK_REPLACE;
				c_idx   = cand_idx_q;
				c_age   = cand_age_q;
				c_birth = cand_birth_q;
			end
			default: begin
				c_kind = RK_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pend_q  <= RK_NONE;
		end else begin
			if (c_set) begin
				valid_q[c_idx] <= 1'b1;
			end
			if (c_clr) begin
				valid_q[c_idx] <= 1'b0;
			end
			if (cmd.upd != UPD_NONE) begin
				pend_q <= c_kind;
			end else if (rd_vld_s1 && (rd_idx_s1 == LAST_IDX)) begin
				pend_q <= RK_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd != UPD_NONE) begin
			pend_idx_q   <= c_idx;
			pend_age_q   <= c_age;
			pend_birth_q <= c_birth;
		end
	end

	assign stat.done       = done_q;
	assign stat.hit        = hit_q;
	assign stat.free_found = free_q;
	assign stat.cand_found = cand_q;
	assign stat.hit_ent    = hit_ent_q;
	assign stat.cand_ent   = cand_ent_q;

endmodule

// ===== rtl/lru_page_write_buffer.sv =====
// Page write buffer, top level: a fully associative table of ENTRIES buffered
// page writes keyed by object and offset, kept in least-recently-used order.
// Every request makes a pass over the table memory, one entry per clock,
// which also applies the rank change left by the previous request; flushing
// an object makes one pass for every entry written out plus one for the final
// terminate beat. A write-through that hits a buffered page and must forward it
// gives a second result beat, and a result beat waits while the output
// register holds a stalled beat. Requests are taken one at a time, while the
// last result of the previous one may still wait in the output register.
module lru_page_write_buffer #(
	parameter int ENTRIES = lpwb_pkg::ENTRIES_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  lpwb_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output lpwb_pkg::rsp_t                   rsp,
	input  logic                             cfg_we,
	input  logic [lpwb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpwb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lpwb_pkg::*;

	state_t                state_q;
	state_t                state_d;
	req_t                  req_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic [1:0]            init_code_q;
	logic [CFG_DATA_W-1:0] page_bytes_q;

	tbl_cmd_t  cmd;
	tbl_stat_t stat;
	rsp_t      res_d;
	logic      push;
	logic      out_free;
	logic      accept;
	logic      wt_split;
	logic      flush_more;
	entry_t    new_ent;

	function automatic rsp_t write_beat(input entry_t e, input logic [CFG_DATA_W-1:0] pb);
		rsp_t r;
		r                 = '0;
		r.action          = ACT_FWD_WRITE;
		r.out_object      = e.object_id;
		r.out_offset      = e.page_offset;
		r.out_handle      = e.handle;
		r.out_dirty       = e.attrs[0];
		r.out_kernel_copy = e.attrs[1];
		r.out_use_mode    = e.attrs[3:2];
		r.out_length      = 32'(pb);
		return r;
	endfunction

	function automatic rsp_t discard_beat(input logic [15:0] obj, input logic [31:0] off,
			input logic [31:0] h);
		rsp_t r;
		r            = '0;
		r.action     = ACT_DISCARD;
		r.out_object = obj;
		r.out_offset = off;
		r.out_handle = h;
		return r;
	endfunction

	lpwb_table #(
		.ENTRIES(ENTRIES)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat)
	);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign new_ent.object_id   = req_q.object_id;
	assign new_ent.page_offset = req_q.page_offset;
	assign new_ent.handle      = req_q.data_handle;
	assign new_ent.attrs       = {req_q.use_mode_in, req_q.kernel_copy_in, req_q.dirty_in};

	// write-through hit outside initialize mode gives two beats
	assign wt_split   = (req_q.operation == OP_WRITE_THROUGH) && stat.hit &&
		(req_q.use_mode_in != init_code_q);
	assign flush_more = (req_q.operation == OP_FLUSH_OBJECT) && stat.cand_found;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (out_free) begin
					if (wt_split) begin
						state_d = ST_SECOND;
					end else if (flush_more) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SECOND: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		push              = 1'b0;
		res_d             = '0;
		res_d.action      = ACT_DONE;
		res_d.last        = 1'b1;
		cmd.start         = 1'b0;
		cmd.flush_search  = (req_q.operation == OP_FLUSH_OBJECT);
		cmd.key_object    = req_q.object_id;
		cmd.key_offset    = req_q.page_offset;
		cmd.upd           = UPD_NONE;
		cmd.wr_en         = 1'b0;
		cmd.wr_ent        = new_ent;
		case (state_q)
			ST_IDLE: begin
				cmd.start = accept;
			end
			ST_DECIDE: begin
				if (out_free) begin
					push = 1'b1;
					case (op_t'(req_q.operation))
						OP_BUF_WRITE: begin
							cmd.wr_en = 1'b1;
							if (stat.hit) begin
								res_d   = discard_beat(req_q.object_id, req_q.page_offset,
									stat.hit_ent.handle);
								cmd.upd = UPD_TOUCH_HIT;
							end else if (stat.free_found) begin
								cmd.upd = UPD_INSERT_FREE;
							end else begin
								// table full: lru entry goes out
								res_d   = write_beat(stat.cand_ent, page_bytes_q);
								cmd.upd = UPD_REPLACE_CAND;
							end
						end
						OP_WRITE_THROUGH: begin
							if (stat.hit && !wt_split) begin
								res_d = discard_beat(req_q.object_id, req_q.page_offset,
									req_q.data_handle);
							end else if (stat.hit) begin
								res_d   = discard_beat(req_q.object_id, req_q.page_offset,
									stat.hit_ent.handle);
								cmd.upd = UPD_DROP_HIT;
							end else begin
								res_d = write_beat(new_ent, page_bytes_q);
							end
						end
						OP_READ: begin
							if (stat.hit) begin
								res_d.action     = ACT_SUPPLY;
								res_d.out_handle = stat.hit_ent.handle;
								cmd.upd          = UPD_TOUCH_HIT;
							end else begin
								res_d.action     = ACT_FWD_READ;
								res_d.out_access = req_q.access_in;
							end
							res_d.out_object = req_q.object_id;
							res_d.out_offset = req_q.page_offset;
							res_d.out_length = req_q.length_in;
						end
						OP_UNBUFFER: begin
							if (stat.hit) begin
								if (req_q.clean) begin
									res_d = write_beat(stat.hit_ent, page_bytes_q);
								end else begin
									res_d = discard_beat(req_q.object_id, req_q.page_offset,
										stat.hit_ent.handle);
								end
								cmd.upd = UPD_DROP_HIT;
							end
						end
						OP_FLUSH_OBJECT: begin
							if (stat.cand_found) begin
								res_d     = write_beat(stat.cand_ent, page_bytes_q);
								cmd.upd   = UPD_DROP_CAND;
								cmd.start = 1'b1;
							end else begin
								res_d.action      = ACT_FWD_TERMINATE;
								res_d.out_object  = req_q.object_id;
								res_d.out_release = req_q.release_in;
							end
						end
						default: begin
							res_d.action = ACT_DONE;
						end
					endcase
					res_d.last = !(wt_split || flush_more);
				end
			end
			ST_SECOND: begin
				if (out_free) begin
					push       = 1'b1;
					res_d      = write_beat(new_ent, page_bytes_q);
					res_d.last = 1'b1;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			init_code_q <= INIT_CODE_RESET;
			page_bytes_q <= PAGE_BYTES_RESET;
		end else begin
			state_q <= state_d;
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_INIT_CODE: init_code_q <= cfg_data[1:0];
					CFG_PAGE_BYTES: page_bytes_q <= cfg_data;
					default: init_code_q <= init_code_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (push) begin
			rsp_q <= res_d;
		end
	end

endmodule

// ===== rtl/lpwb_checker.sv =====
// port-level checks of the page write buffer and their binding to the top level
module lpwb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input lpwb_pkg::rsp_t rsp
);
	import lpwb_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// one request at a time: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while a request is in work");

	// result beats only come out of work on a request
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result beat without a request in work");

	a_terminate_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.action == ACT_FWD_TERMINATE) |->
		rsp.last && (rsp.out_offset == '0) && (rsp.out_handle == '0))
		else $error("terminate beat malformed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.action == ACT_DONE) |-> rsp.last)
		else $error("done beat not marked last");

endmodule

bind lru_page_write_buffer lpwb_checker u_lpwb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

// ===== dv/lru_page_write_buffer_tb.sv =====
// page write buffer testbench: table predictor and beat scoreboard under random traffic and stalls
module lru_page_write_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpwb_pkg::*;

	localparam int ENT        = 32;
	localparam int IDLE_LIMIT = 4000;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lru_page_write_buffer #(.ENTRIES(ENT)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predicted table contents and settings
	bit          pg_valid [ENT];
	logic [15:0] pg_object[ENT];
	logic [31:0] pg_offset[ENT];
	logic [31:0] pg_handle[ENT];
	logic [3:0]  pg_attrs [ENT];
	int          pg_age   [ENT];
	int          pg_birth [ENT];
	logic [1:0]  init_code_q;
	logic [16:0] page_bytes_q;

	rsp_t pending_beats[$];

	logic [15:0] pool_obj[4];
	logic [31:0] pool_off[12];

	bit steady;
	int err_cnt;
	int items_sent;
	int beats_seen;
	int evictions;
	int flushes;

	function automatic void reset_predictor();
		for (int i = 0; i < ENT; i++) begin
			pg_valid[i]  = 1'b0;
			pg_object[i] = '0;
			pg_offset[i] = '0;
			pg_handle[i] = '0;
			pg_attrs[i]  = '0;
			pg_age[i]    = 0;
			pg_birth[i]  = 0;
		end
		init_code_q  = INIT_CODE_RESET;
		page_bytes_q = PAGE_BYTES_RESET;
	endfunction

	function automatic int find_page(logic [15:0] o, logic [31:0] f);
		for (int i = 0; i < ENT; i++)
			if (pg_valid[i] && pg_object[i] == o && pg_offset[i] == f)
				return i;
		return -1;
	endfunction

	function automatic void touch_page(int i);
		for (int j = 0; j < ENT; j++)
			if (pg_valid[j] && j != i && pg_age[j] < pg_age[i])
				pg_age[j]++;
		pg_age[i] = 0;
	endfunction

	function automatic void drop_page(int i);
		for (int j = 0; j < ENT; j++) begin
			if (pg_valid[j] && j != i) begin
				if (pg_age[j] > pg_age[i])
					pg_age[j]--;
				if (pg_birth[j] > pg_birth[i])
					pg_birth[j]--;
			end
		end
		pg_valid[i] = 1'b0;
	endfunction

	function automatic void insert_page(int i, logic [15:0] o, logic [31:0] f,
			logic [31:0] h, logic [3:0] at);
		for (int j = 0; j < ENT; j++) begin
			if (pg_valid[j]) begin
				pg_age[j]++;
				pg_birth[j]++;
			end
		end
		pg_valid[i]  = 1'b1;
		pg_object[i] = o;
		pg_offset[i] = f;
		pg_handle[i] = h;
		pg_attrs[i]  = at;
		pg_age[i]    = 0;
		pg_birth[i]  = 0;
	endfunction

	function automatic rsp_t make_beat(act_t a, logic [15:0] o, logic [31:0] f,
			logic [31:0] h, logic [3:0] at, logic [31:0] len, logic [2:0] acc, logic rel);
		rsp_t b;
		b.action          = a;
		b.out_object      = o;
		b.out_offset      = f;
		b.out_handle      = h;
		b.out_dirty       = at[0];
		b.out_kernel_copy = at[1];
		b.out_use_mode    = at[3:2];
		b.out_length      = len;
		b.out_access      = acc;
		b.out_release     = rel;
		b.last            = 1'b0;
		return b;
	endfunction

	function automatic rsp_t write_back_beat(int i);
		return make_beat(ACT_FWD_WRITE, pg_object[i], pg_offset[i], pg_handle[i],
			pg_attrs[i], {15'd0, page_bytes_q}, 3'd0, 1'b0);
	endfunction

	// works out the result beats of one accepted request and updates the table
	function automatic void predict_beats(req_t r);
		rsp_t        beats[$];
		rsp_t        tail;
		int          hit;
		int          slot;
		int          pick;
		logic [3:0]  at;
		logic [31:0] pb;
		hit = find_page(r.object_id, r.page_offset);
		at  = {r.use_mode_in, r.kernel_copy_in, r.dirty_in};
		pb  = {15'd0, page_bytes_q};
		case (r.operation)
			OP_BUF_WRITE: begin
				if (hit >= 0) begin
					beats.push_back(make_beat(ACT_DISCARD, r.object_id, r.page_offset,
						pg_handle[hit], 4'd0, 32'd0, 3'd0, 1'b0));
					pg_handle[hit] = r.data_handle;
					pg_attrs[hit]  = at;
					touch_page(hit);
				end else begin
					slot = -1;
					for (int j = 0; j < ENT; j++)
						if (!pg_valid[j] && slot < 0)
							slot = j;
					if (slot >= 0) begin
						insert_page(slot, r.object_id, r.page_offset, r.data_handle, at);
						beats.push_back(make_beat(ACT_DONE, 16'd0, 32'd0, 32'd0, 4'd0,
							32'd0, 3'd0, 1'b0));
					end else begin
						slot = 0;
						for (int j = 1; j < ENT; j++)
							if (pg_age[j] > pg_age[slot])
								slot = j;
						beats.push_back(write_back_beat(slot));
						drop_page(slot);
						insert_page(slot, r.object_id, r.page_offset, r.data_handle, at);
						evictions++;
					end
				end
			end
			OP_WRITE_THROUGH: begin
				if (hit >= 0 && r.use_mode_in == init_code_q) begin
					beats.push_back(make_beat(ACT_DISCARD, r.object_id, r.page_offset,
						r.data_handle, 4'd0, 32'd0, 3'd0, 1'b0));
				end else begin
					if (hit >= 0) begin
						beats.push_back(make_beat(ACT_DISCARD, r.object_id, r.page_offset,
							pg_handle[hit], 4'd0, 32'd0, 3'd0, 1'b0));
						drop_page(hit);
					end
					beats.push_back(make_beat(ACT_FWD_WRITE, r.object_id, r.page_offset,
						r.data_handle, at, pb, 3'd0, 1'b0));
				end
			end
			OP_READ: begin
				if (hit >= 0) begin
					touch_page(hit);
					beats.push_back(make_beat(ACT_SUPPLY, r.object_id, r.page_offset,
						pg_handle[hit], 4'd0, r.length_in, 3'd0, 1'b0));
				end else begin
					beats.push_back(make_beat(ACT_FWD_READ, r.object_id, r.page_offset,
						32'd0, 4'd0, r.length_in, r.access_in, 1'b0));
				end
			end
			OP_UNBUFFER: begin
				if (hit < 0) begin
					beats.push_back(make_beat(ACT_DONE, 16'd0, 32'd0, 32'd0, 4'd0,
						32'd0, 3'd0, 1'b0));
				end else begin
					if (r.clean)
						beats.push_back(write_back_beat(hit));
					else
						beats.push_back(make_beat(ACT_DISCARD, r.object_id, r.page_offset,
							pg_handle[hit], 4'd0, 32'd0, 3'd0, 1'b0));
					drop_page(hit);
				end
			end
			OP_FLUSH_OBJECT: begin
				// oldest insertion goes out first
				do begin
					pick = -1;
					for (int j = 0; j < ENT; j++)
						if (pg_valid[j] && pg_object[j] == r.object_id &&
								(pick < 0 || pg_birth[j] > pg_birth[pick]))
							pick = j;
					if (pick >= 0) begin
						beats.push_back(write_back_beat(pick));
						drop_page(pick);
					end
				end while (pick >= 0);
				beats.push_back(make_beat(ACT_FWD_TERMINATE, r.object_id, 32'd0, 32'd0,
					4'd0, 32'd0, 3'd0, r.release_in));
				flushes++;
			end
			default: begin
				beats.push_back(make_beat(ACT_DONE, 16'd0, 32'd0, 32'd0, 4'd0,
					32'd0, 3'd0, 1'b0));
			end
		endcase
		tail = beats.pop_back();
		tail.last = 1'b1;
		beats.push_back(tail);
		foreach (beats[k])
			pending_beats.push_back(beats[k]);
	endfunction

	function automatic string beat_str(rsp_t b);
		return $sformatf("act=%0d obj=%h off=%h hdl=%h d=%b k=%b m=%0d len=%h acc=%0d rel=%b last=%b",
			b.action, b.out_object, b.out_offset, b.out_handle, b.out_dirty,
			b.out_kernel_copy, b.out_use_mode, b.out_length, b.out_access,
			b.out_release, b.last);
	endfunction

	function automatic string beat_diff(rsp_t e, rsp_t g);
		string s;
		s = "";
		if (g.action !== e.action)                   s = {s, " action"};
		if (g.out_object !== e.out_object)           s = {s, " out_object"};
		if (g.out_offset !== e.out_offset)           s = {s, " out_offset"};
		if (g.out_handle !== e.out_handle)           s = {s, " out_handle"};
		if (g.out_dirty !== e.out_dirty)             s = {s, " out_dirty"};
		if (g.out_kernel_copy !== e.out_kernel_copy) s = {s, " out_kernel_copy"};
		if (g.out_use_mode !== e.out_use_mode)       s = {s, " out_use_mode"};
		if (g.out_length !== e.out_length)           s = {s, " out_length"};
		if (g.out_access !== e.out_access)           s = {s, " out_access"};
		if (g.out_release !== e.out_release)         s = {s, " out_release"};
		if (g.last !== e.last)                       s = {s, " last"};
		return s;
	endfunction

	// result side: every accepted beat against the oldest predicted one
	always @(posedge clk) begin : check_beats
		rsp_t  exp_b;
		string diff;
		if (arst_n && rsp_valid && !rsp_stall) begin
			beats_seen++;
			if (pending_beats.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected beat: %s", beat_str(rsp));
			end else begin
				exp_b = pending_beats.pop_front();
				diff  = beat_diff(exp_b, rsp);
				if (diff != "") begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("beat %0d mismatch:%s\n  want %s\n  got  %s",
							beats_seen, diff, beat_str(exp_b), beat_str(rsp));
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : rsp_side
		int stall_left;
		rsp_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				rsp_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic req_t random_req();
		req_t r;
		r.operation      = 3'($urandom_range(0, 4));
		r.object_id      = 16'($urandom);
		r.page_offset    = $urandom;
		r.data_handle    = $urandom;
		r.dirty_in       = 1'($urandom);
		r.kernel_copy_in = 1'($urandom);
		r.use_mode_in    = 2'($urandom);
		r.clean          = 1'($urandom);
		r.length_in      = $urandom;
		r.access_in      = 3'($urandom);
		r.release_in     = 1'($urandom);
		return r;
	endfunction

	function automatic req_t key_req(op_t op, logic [15:0] o, logic [31:0] f);
		req_t r;
		r             = random_req();
		r.operation   = op;
		r.object_id   = o;
		r.page_offset = f;
		return r;
	endfunction

	function automatic req_t pool_req(op_t op);
		return key_req(op, pool_obj[$urandom_range(0, 3)], pool_off[$urandom_range(0, 11)]);
	endfunction

	function automatic void refresh_pool();
		foreach (pool_obj[i])
			pool_obj[i] = 16'($urandom);
		foreach (pool_off[i])
			pool_off[i] = $urandom;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_beats(item);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_beats();
		req_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		drain_beats();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_INIT_CODE)
			init_code_q = data[1:0];
		else
			page_bytes_q = data;
	endtask

	task automatic test_directed();
		req_t r;
		// read miss with the widest length and access
		r = key_req(OP_READ, 16'h0000, 32'h0000_0000);
		r.length_in = '1;
		r.access_in = '1;
		send_item(r);
		// fill a free entry, then rewrite it
		r = key_req(OP_BUF_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
		r.data_handle    = '1;
		r.dirty_in       = 1'b1;
		r.kernel_copy_in = 1'b1;
		r.use_mode_in    = 2'd3;
		send_item(r);
		r = key_req(OP_BUF_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
		r.data_handle    = '0;
		r.dirty_in       = 1'b0;
		r.kernel_copy_in = 1'b0;
		r.use_mode_in    = 2'd0;
		send_item(r);
		// read hit supplies the buffered handle
		r = key_req(OP_READ, 16'hFFFF, 32'hFFFF_FFFF);
		r.length_in = '0;
		r.access_in = '0;
		send_item(r);
		// write-through on a buffered page: initialize mode drops the new data
		r = key_req(OP_WRITE_THROUGH, 16'hFFFF, 32'hFFFF_FFFF);
		r.use_mode_in = INIT_CODE_RESET;
		send_item(r);
		// any other mode frees the entry and forwards
		r = key_req(OP_WRITE_THROUGH, 16'hFFFF, 32'hFFFF_FFFF);
		r.use_mode_in = 2'd2;
		send_item(r);
		r = key_req(OP_WRITE_THROUGH, 16'hFFFF, 32'hFFFF_FFFF);
		r.use_mode_in = 2'd0;
		send_item(r);
		r = key_req(OP_UNBUFFER, 16'h0000, 32'h0000_0000);
		send_item(r);
		// initialize mode on a buffered write is still buffered, then cleaned
		r = key_req(OP_BUF_WRITE, 16'h1234, 32'h0000_1000);
		r.use_mode_in = INIT_CODE_RESET;
		send_item(r);
		r.operation = OP_UNBUFFER;
		r.clean     = 1'b1;
		send_item(r);
		r = key_req(OP_BUF_WRITE, 16'h1234, 32'h0000_2000);
		send_item(r);
		r.operation = OP_UNBUFFER;
		r.clean     = 1'b0;
		send_item(r);
		// flush order follows insertion, not recency
		for (int k = 0; k < 3; k++) begin
			r = key_req(OP_BUF_WRITE, 16'h00A5, 32'h0001_0000 * (k + 1));
			send_item(r);
		end
		r = key_req(OP_READ, 16'h00A5, 32'h0001_0000);
		send_item(r);
		r = key_req(OP_FLUSH_OBJECT, 16'h00A5, $urandom);
		r.release_in = 1'b1;
		send_item(r);
		// nothing buffered for this object: terminate only
		r = key_req(OP_FLUSH_OBJECT, 16'h5A5A, 32'h0);
		r.release_in = 1'b0;
		send_item(r);
		for (int c = 5; c < 8; c++) begin
			r = random_req();
			r.operation = 3'(c);
			send_item(r);
		end
	endtask

	task automatic test_table_full();
		req_t r;
		write_reg(CFG_INIT_CODE, 17'd0);
		write_reg(CFG_PAGE_BYTES, 17'd1);
		// fresh keys fill the table and then evict, with no idling at all
		steady = 1'b1;
		for (int k = 0; k < 45; k++) begin
			r = random_req();
			r.operation = OP_BUF_WRITE;
			send_item(r);
		end
		steady = 1'b0;
	endtask

	task automatic test_flush_whole_table();
		req_t        r;
		logic [15:0] o;
		write_reg(CFG_INIT_CODE, 17'd3);
		write_reg(CFG_PAGE_BYTES, 17'd65536);
		o = 16'($urandom);
		for (int k = 0; k < ENT; k++) begin
			r = key_req(OP_BUF_WRITE, o, $urandom);
			send_item(r);
		end
		r = key_req(OP_FLUSH_OBJECT, o, $urandom);
		send_item(r);
	endtask

	task automatic test_mixed_traffic(int n, logic [1:0] code, logic [16:0] bytes);
		req_t r;
		int   sel;
		write_reg(CFG_INIT_CODE, {15'd0, code});
		write_reg(CFG_PAGE_BYTES, bytes);
		refresh_pool();
		for (int k = 0; k < n; k++) begin
			steady = (k >= n / 2 && k < n / 2 + 20);
			sel = $urandom_range(0, 99);
			if (sel < 38) begin
				r = pool_req(OP_BUF_WRITE);
			end else if (sel < 52) begin
				r = pool_req(OP_WRITE_THROUGH);
				if ($urandom_range(0, 1))
					r.use_mode_in = init_code_q;
			end else if (sel < 70) begin
				r = pool_req(OP_READ);
			end else if (sel < 84) begin
				r = pool_req(OP_UNBUFFER);
			end else if (sel < 90) begin
				r = pool_req(OP_FLUSH_OBJECT);
			end else if (sel < 96) begin
				r = random_req();
			end else begin
				r = random_req();
				r.operation = 3'($urandom_range(5, 7));
			end
			send_item(r);
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		steady     = 1'b0;
		err_cnt    = 0;
		items_sent = 0;
		beats_seen = 0;
		evictions  = 0;
		flushes    = 0;
		reset_predictor();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_table_full();
		test_flush_whole_table();
		test_mixed_traffic(120, 2'd0, 17'($urandom_range(1, 65536)));
		test_mixed_traffic(120, 2'd3, 17'd1);
		test_mixed_traffic(120, 2'd2, 17'd65536);

		drain_beats();
		repeat (ENT + 8) @(posedge clk);
		if (pending_beats.size() != 0)
			err_cnt++;
		$display("run covered %0d requests and %0d result beats across six register settings",
			items_sent, beats_seen);
		$display("including %0d evictions from a full table and %0d object flushes",
			evictions, flushes);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
